[rtl/splitmix64_random_source_defines.svh]
// Assertion macros shared by the checker of the random source.
`ifndef SPLITMIX64_RANDOM_SOURCE_DEFINES_SVH
`define SPLITMIX64_RANDOM_SOURCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SM64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define SM64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sm64_pkg.sv]
// Package: constants, request codes and widths of the SplitMix64 random source.
`timescale 1ns / 1ps
package sm64_pkg;

    localparam int WORD_W  = 64;
    localparam int DIGIT_W = 4;
    localparam int NUM_DIGITS = WORD_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(NUM_DIGITS);
    localparam int COUNT_W = 7;
    localparam int RES_W   = 32;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] SEED_XOR     = 64'h6a09e667f3bcc909;

    // Request codes
    localparam logic [1:0] REQ_STIR = 2'd0;
    localparam logic [1:0] REQ_WORD = 2'd1;
    localparam logic [1:0] REQ_FILL = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

endpackage

[rtl/sm64_mul.sv]
// Digit-serial 64 x 64 multiplier, product modulo 2^64, one 4-bit digit a cycle.
`timescale 1ns / 1ps
module sm64_mul
    import sm64_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t product
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    word_t             a_reg, a_next;
    word_t             b_reg, b_next;
    word_t             acc_reg, acc_next;
    word_t             partial;

    // One partial product per cycle: multiplicand times the low digit
    assign partial = a_reg * word_t'(b_reg[DIGIT_W-1:0]);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial;
            a_next   = a_reg << DIGIT_W;
            b_next   = b_reg >> DIGIT_W;
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(NUM_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers and accumulator
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/splitmix64_random_source.sv]
// Top level: SplitMix64 random source with time-based stirring and byte buffer fill.
// Each 64-bit multiply runs as a start, 16 digit steps and a done.
// Stir: one seed multiply. Word: two mixing multiplies, plus a seed multiply when unseeded.
// Fill of N bytes: one draw of two mixing multiplies per 8 bytes, then a load and a send per byte beat.
// One request at a time; a new request is taken once the last beat has gone.
// Reset clears generator state, stir counter and seeded flag; no clearing pass.
`timescale 1ns / 1ps
module splitmix64_random_source
    import sm64_pkg::*;
#(
    parameter int MAX_BYTES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [63:0]        time_value,
    input  logic [COUNT_W-1:0] byte_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [RES_W-1:0]   result_value,
    output logic               result_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STIR = 3'd1;
    localparam logic [2:0] S_DRAW = 3'd2;
    localparam logic [2:0] S_MIX1 = 3'd3;
    localparam logic [2:0] S_MIX2 = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;
    localparam logic [2:0] S_SEND = 3'd6;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_BYTES);

    logic [2:0]         state_reg, state_next;
    word_t              gen_reg, gen_next;
    word_t              stir_cnt_reg, stir_cnt_next;
    logic               seeded_reg, seeded_next;
    logic [1:0]         type_reg, type_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    word_t              time_reg, time_next;
    word_t              v_reg, v_next;
    logic [RES_W-1:0]   value_reg, value_next;
    logic               last_reg, last_next;

    logic               in_beat, out_beat;
    logic               mul_start, mul_done;
    word_t              mul_a, mul_b, mul_p;
    word_t              seed, gen_step;
    logic [COUNT_W-1:0] count_sat, idx_inc;

    sm64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid_reg && out_ready;
    assign count_sat = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;
    assign seed      = time_reg ^ mul_p;
    assign gen_step  = gen_reg + GOLDEN_GAMMA;
    assign idx_inc   = idx_reg + COUNT_W'(1);

    // Request sequencer
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        stir_cnt_next  = stir_cnt_reg;
        seeded_next    = seeded_reg;
        type_next      = type_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        time_next      = time_reg;
        v_next         = v_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        mul_start      = 1'b0;
        mul_a          = stir_cnt_reg;
        mul_b          = GOLDEN_GAMMA;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    type_next  = req_type;
                    time_next  = time_value;
                    count_next = count_sat;
                    idx_next   = '0;
                    case (req_type) inside
                        REQ_STIR:
                        begin
                            mul_start  = 1'b1;
                            state_next = S_STIR;
                        end
                        REQ_WORD, REQ_FILL:
                        begin
                            if (!seeded_reg)
                            begin
                                mul_start  = 1'b1;
                                state_next = S_STIR;
                            end
                            else if (req_type == REQ_FILL && count_sat == '0)
                                state_next = S_IDLE;
                            else
                                state_next = S_DRAW;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            // Seed mixing: time xor golden multiple of the stir counter
            S_STIR:
            begin
                if (mul_done)
                begin
                    stir_cnt_next = stir_cnt_reg + WORD_W'(1);
                    seeded_next   = 1'b1;
                    gen_next      = seeded_reg ? (gen_reg ^ seed) : (seed ^ SEED_XOR);
                    if (type_reg == REQ_STIR)
                        state_next = S_IDLE;
                    else if (type_reg == REQ_FILL && count_reg == '0)
                        state_next = S_IDLE;
                    else
                        state_next = S_DRAW;
                end
            end

            // Advance the state and start the first mixing multiply
            S_DRAW:
            begin
                gen_next   = gen_step;
                mul_start  = 1'b1;
                mul_a      = gen_step ^ (gen_step >> 30);
                mul_b      = MIX_MUL_A;
                state_next = S_MIX1;
            end

            S_MIX1:
            begin
                mul_a = mul_p ^ (mul_p >> 27);
                mul_b = MIX_MUL_B;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MIX2;
                end
            end

            S_MIX2:
            begin
                if (mul_done)
                begin
                    v_next     = mul_p ^ (mul_p >> 31);
                    state_next = S_LOAD;
                end
            end

            // Put the next word or byte into the output register
            S_LOAD:
            begin
                out_valid_next = 1'b1;
                if (type_reg == REQ_WORD)
                begin
                    value_next = v_reg[63:32];
                    last_next  = 1'b1;
                end
                else
                begin
                    value_next = {{(RES_W-8){1'b0}}, v_reg[7:0]};
                    last_next  = (idx_inc == count_reg);
                    v_next     = v_reg >> 8;
                end
                state_next = S_SEND;
            end

            S_SEND:
            begin
                if (out_beat)
                begin
                    out_valid_next = 1'b0;
                    idx_next       = idx_inc;
                    if (last_reg)
                        state_next = S_IDLE;
                    else if (idx_inc[2:0] == 3'd0)
                        state_next = S_DRAW;
                    else
                        state_next = S_LOAD;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= '0;
            stir_cnt_reg  <= '0;
            seeded_reg    <= 1'b0;
            type_reg      <= REQ_STIR;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            stir_cnt_reg  <= stir_cnt_next;
            seeded_reg    <= seeded_next;
            type_reg      <= type_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        v_reg     <= v_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign result_last  = last_reg;

endmodule

[rtl/sm64_checker.sv]
// Port-level checker for the random source, bound to the top level.
`timescale 1ns / 1ps
`include "splitmix64_random_source_defines.svh"
module sm64_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic [63:0] time_value,
    input logic [6:0]  byte_count,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic        result_last
);

    // A waiting request beat holds its payload
    `SM64_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(req_type) && $stable(time_value) && $stable(byte_count), "request beat changed while waiting")

    // A stalled result beat holds its payload
    `SM64_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(result_last), "result beat changed while stalled")

    // No new request is taken while a result is pending
    `SM64_ASSERT_NOW(a_busy_out, out_valid, !in_ready, "request taken while result pending")

    // More beats follow a non-final beat, so the block stays busy
    `SM64_ASSERT_NEXT(a_busy_more, out_valid && out_ready && !result_last, !in_ready, "block went idle before final beat")

    // Non-final beats are byte beats and carry zero in the upper bits; only the word beat is wide
    `SM64_ASSERT_NOW(a_byte_width, out_valid && !result_last, result_value[31:8] == 24'd0, "byte beat with upper bits set")

endmodule

bind splitmix64_random_source sm64_checker u_sm64_checker (.*);

[tb/sv/splitmix64_random_source_test.sv]
// Self-checking testbench for the SplitMix64 random source: stir, word and byte fill requests.
`timescale 1ns / 1ps
module splitmix64_random_source_test;
    import sm64_pkg::*;

    localparam int          FILL_MAX    = 64;
    localparam int          QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int          HOLD_LEN    = 350;   // long receiver hold-off
    localparam int          TAIL_CYCLES = 100;   // covers a trailing stir
    localparam int          REPORT_MAX  = 10;
    localparam logic [1:0]  REQ_UNDEF   = 2'd3;  // not decoded by the block

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             last;
    } beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = REQ_STIR;
    logic [63:0]        time_value = '0;
    logic [COUNT_W-1:0] byte_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [RES_W-1:0]   result_value;
    logic               result_last;

    // Generator copy kept by the testbench
    logic [63:0] gen_state;
    logic [63:0] stir_total;
    logic        seeded;

    beat_t pending_beats[$];
    int    mismatches = 0;
    int    quiet_cycles = 0;
    int    hold_left = 0;
    int    hold_asks = 0;
    int    hold_seen = 0;
    logic  steady = 1'b0;

    splitmix64_random_source #(
        .MAX_BYTES(FILL_MAX)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .time_value  (time_value),
        .byte_count  (byte_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_value(result_value),
        .result_last (result_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Generator arithmetic
    // ---------------------------------------------------------------

    // One SplitMix64 step, modulo 2^64
    function automatic logic [63:0] advance_draw();
        logic [63:0] z;
        gen_state = gen_state + GOLDEN_GAMMA;
        z = gen_state;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Mix a time value with the golden-ratio multiple of the stir counter
    function automatic void absorb_time(input logic [63:0] t);
        logic [63:0] seed;
        seed = t ^ (stir_total * GOLDEN_GAMMA);
        stir_total = stir_total + 64'd1;
        if (!seeded)
        begin
            gen_state = seed ^ SEED_XOR;
            seeded = 1'b1;
        end
        else
        begin
            gen_state = gen_state ^ seed;
        end
    endfunction

    // Expected beats of one accepted request
    function automatic void predict_request(input logic [1:0] kind, input logic [63:0] t,
                                            input logic [COUNT_W-1:0] cnt);
        int          total;
        logic [63:0] draw;
        beat_t       b;
        draw = '0;
        case (kind)
            REQ_STIR:
            begin
                absorb_time(t);
            end
            REQ_WORD:
            begin
                if (!seeded)
                    absorb_time(t);
                draw = advance_draw();
                b.value = draw[63:32];
                b.last = 1'b1;
                pending_beats.push_back(b);
            end
            REQ_FILL:
            begin
                if (!seeded)
                    absorb_time(t);
                total = (cnt > FILL_MAX) ? FILL_MAX : int'(cnt);
                for (int n = 0; n < total; n++)
                begin
                    if ((n % 8) == 0)
                        draw = advance_draw();
                    b.value = {{(RES_W-8){1'b0}}, draw[7:0]};
                    b.last = (n + 1 == total);
                    pending_beats.push_back(b);
                    draw = draw >> 8;
                end
            end
            default:
            begin
                // undecoded request: ignored
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver side: random idling, long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 35);
    end

    // Result checking against the oldest expected beat
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: value %h last %b", result_value, result_last);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (result_value !== want.value || result_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("beat mismatch: expected %h/%b, got %h/%b",
                                 want.value, want.last, result_value, result_last);
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sender helpers
    // ---------------------------------------------------------------

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic send_request(input logic [1:0] kind, input logic [63:0] t,
                                input logic [COUNT_W-1:0] cnt);
        int gap;
        if (!steady && $urandom_range(99) < 35)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        time_value <= t;
        byte_count <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(kind, t, cnt);
    endtask

    // Sender pauses until every expected beat has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_time();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return '0;
        if (sel < 10)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly short fills, some longer ones up to the cap, a few above the cap
    function automatic logic [COUNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return COUNT_W'($urandom_range(0, 16));
        if (sel < 90)
            return COUNT_W'($urandom_range(17, FILL_MAX));
        return COUNT_W'($urandom_range(FILL_MAX + 1, 127));
    endfunction

    task automatic send_random_request();
        int          sel;
        logic [1:0]  kind;
        sel = $urandom_range(99);
        if (sel < 15)
            kind = REQ_STIR;
        else if (sel < 50)
            kind = REQ_WORD;
        else if (sel < 95)
            kind = REQ_FILL;
        else
            kind = REQ_UNDEF;
        send_request(kind, pick_time(), pick_count());
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Undecoded request first, then an empty fill that must still seed
    task automatic test_directed();
        send_request(REQ_UNDEF, 64'h0123_4567_89ab_cdef, 7'd5);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd0);
        send_request(REQ_WORD, 64'hffff_ffff_ffff_ffff, 7'd0);
        send_request(REQ_STIR, 64'h0000_0000_0000_0000, 7'd0);
        send_request(REQ_STIR, 64'hffff_ffff_ffff_ffff, 7'd127);
        send_request(REQ_WORD, 64'h0000_0000_0000_0000, 7'd127);
        send_request(REQ_FILL, 64'h5555_5555_5555_5555, 7'd1);
        send_request(REQ_FILL, 64'haaaa_aaaa_aaaa_aaaa, 7'd7);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd8);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd9);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd64);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd65);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd127);
        send_request(REQ_FILL, 64'h0000_0000_0000_0000, 7'd0);
        send_request(REQ_UNDEF, 64'hffff_ffff_ffff_ffff, 7'd64);
        send_request(REQ_WORD, 64'h8000_0000_0000_0001, 7'd42);
        wait_drained();
    endtask

    // Receiver holds off while requests keep coming; input must stall
    task automatic test_output_stall();
        hold_asks <= hold_asks + 1;
        send_request(REQ_FILL, pick_time(), 7'd64);
        send_request(REQ_WORD, pick_time(), 7'd0);
        send_request(REQ_FILL, pick_time(), 7'd40);
        send_request(REQ_STIR, pick_time(), 7'd0);
        send_request(REQ_WORD, pick_time(), 7'd3);
        send_request(REQ_FILL, pick_time(), 7'd64);
        wait_drained();
    endtask

    task automatic test_random_mix(input int items);
        for (int i = 0; i < items; i++)
            send_random_request();
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        steady <= 1'b1;
        for (int i = 0; i < 40; i++)
            send_random_request();
        wait_drained();
        steady <= 1'b0;
    endtask

    initial
    begin
        gen_state = '0;
        stir_total = '0;
        seeded = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_stall();
        test_random_mix(180);
        test_back_to_back();
        test_random_mix(170);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_beats.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches, %0d beats missing", mismatches, pending_beats.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[splitmix64_random_source.f]
+incdir+rtl
rtl/sm64_pkg.sv
rtl/sm64_mul.sv
rtl/splitmix64_random_source.sv
rtl/sm64_checker.sv
tb/sv/splitmix64_random_source_test.sv
